// ===== design/shp_pkg.sv =====
`timescale 1ns / 1ps
package shp_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int FILL_W   = 9;
  localparam int SEQ_W    = 16;
  localparam int TAG_W    = 32;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    kind_t             kind;
    logic [SEQ_W-1:0]  in_seq;
    logic [TAG_W-1:0]  in_tag;
  } in_t;

  typedef struct packed {
    logic              out_valid;
    logic [SEQ_W-1:0]  out_seq;
    logic [TAG_W-1:0]  out_tag;
    status_t           status;
    logic [FILL_W-1:0] fill_count;
  } out_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_RD,
    S_PUSH_CMP,
    S_POP_LD,
    S_DN_RD,
    S_DN_CMP,
    S_FIN
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    push_init;
    logic    push_rd;
    logic    push_step;
    logic    pop_rd;
    logic    pop_load;
    logic    dn_rd;
    logic    dn_step;
    logic    place;
    logic    load_out;
    logic    res_pop;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic at_root;
    logic leaf;
    logic up_stop;
    logic dn_stop;
  } stat_t;

  // serial order: a precedes b when (a - b) mod 2^16 has its top bit set
  function automatic logic serial_earlier(input logic [SEQ_W-1:0] a,
                                          input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    return d[SEQ_W-1];
  endfunction

endpackage

// ===== design/shp_datapath.sv =====
`timescale 1ns / 1ps
module shp_datapath (
  input  logic          clk,
  input  logic          rst_n,
  input  shp_pkg::in_t  in_data,
  input  shp_pkg::cmd_t cmd,
  output shp_pkg::stat_t stat,
  output shp_pkg::out_t out_data
);
  import shp_pkg::*;

  entry_t           mem_r [CAPACITY];
  entry_t           rda_r, rdb_r;
  entry_t           item_r, item_nxt;
  entry_t           popped_r, popped_nxt;
  out_t             out_data_r, out_data_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [IDX_W-1:0] parent_idx, child_idx, right_idx, chosen_idx, last_idx;
  logic [IDX_W+1:0] child_w, right_w, cnt_ext;
  logic             right_ok, pick_right;
  entry_t           chosen;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_a_addr, rd_b_addr;
  entry_t           wr_data;

  always_comb begin
    parent_idx = (pos_r - 1'b1) >> 1;
    child_w    = {1'b0, pos_r, 1'b1};
    right_w    = child_w + 1'b1;
    cnt_ext    = (IDX_W + 2)'(cnt_r);
    child_idx  = child_w[IDX_W-1:0];
    right_idx  = right_w[IDX_W-1:0];
    last_idx   = IDX_W'(cnt_r - 1'b1);
    right_ok   = right_w < cnt_ext;
    pick_right = right_ok && serial_earlier(rdb_r.seq, rda_r.seq);
    chosen     = pick_right ? rdb_r : rda_r;
    chosen_idx = pick_right ? right_idx : child_idx;

    stat.empty   = cnt_r == '0;
    stat.full    = cnt_r >= CNT_W'(CAPACITY);
    stat.at_root = pos_r == '0;
    stat.leaf    = child_w >= cnt_ext;
    stat.up_stop = serial_earlier(rda_r.seq, item_r.seq);
    stat.dn_stop = serial_earlier(item_r.seq, chosen.seq);
  end

  always_comb begin
    rd_en     = cmd.push_rd | cmd.pop_rd | cmd.dn_rd;
    rd_a_addr = cmd.push_rd ? parent_idx : (cmd.pop_rd ? '0 : child_idx);
    rd_b_addr = cmd.pop_rd ? last_idx : right_idx;

    wr_en   = cmd.place | cmd.push_step | cmd.dn_step;
    wr_data = item_r;
    if (cmd.push_step && !stat.up_stop) begin
      wr_data = rda_r;
    end else if (cmd.dn_step && !stat.dn_stop) begin
      wr_data = chosen;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[pos_r] <= wr_data;
    end
    if (rd_en) begin
      rda_r <= mem_r[rd_a_addr];
      rdb_r <= mem_r[rd_b_addr];
    end
  end

  always_comb begin
    item_nxt     = item_r;
    popped_nxt   = popped_r;
    pos_nxt      = pos_r;
    cnt_nxt      = cnt_r;
    out_data_nxt = out_data_r;
    if (cmd.capture) begin
      item_nxt.seq = in_data.in_seq;
      item_nxt.tag = in_data.in_tag;
    end
    if (cmd.push_init) begin
      pos_nxt = IDX_W'(cnt_r);
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.push_step && !stat.up_stop) begin
      pos_nxt = parent_idx;
    end
    if (cmd.pop_load) begin
      popped_nxt = rda_r;
      item_nxt   = rdb_r;
      pos_nxt    = '0;
      cnt_nxt    = cnt_r - 1'b1;
    end
    if (cmd.dn_step && !stat.dn_stop) begin
      pos_nxt = chosen_idx;
    end
    if (cmd.load_out) begin
      out_data_nxt.out_valid  = cmd.res_pop;
      out_data_nxt.out_seq    = cmd.res_pop ? popped_r.seq : '0;
      out_data_nxt.out_tag    = cmd.res_pop ? popped_r.tag : '0;
      out_data_nxt.status     = cmd.res_status;
      out_data_nxt.fill_count = FILL_W'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    popped_r   <= popped_nxt;
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign out_data = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_init |-> !stat.full)
    else $error("push started on full heap");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_rd |-> !stat.empty)
    else $error("pop started on empty heap");

endmodule

// ===== design/shp_controller.sv =====
`timescale 1ns / 1ps
module shp_controller (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  shp_pkg::kind_t in_kind,
  output logic           out_valid,
  input  logic           out_stall,
  input  shp_pkg::stat_t stat,
  output shp_pkg::cmd_t  cmd
);
  import shp_pkg::*;

  state_t  state_r, state_nxt;
  status_t res_status_r, res_status_nxt;
  logic    res_pop_r, res_pop_nxt;
  logic    out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      res_status_r <= ST_OK;
      res_pop_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      res_status_r <= res_status_nxt;
      res_pop_r    <= res_pop_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_pop_nxt    = res_pop_r;
    out_valid_nxt  = out_valid_r & out_stall;
    cmd            = '0;
    cmd.res_pop    = res_pop_r;
    cmd.res_status = res_status_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture    = 1'b1;
          res_status_nxt = ST_OK;
          res_pop_nxt    = 1'b0;
          if (in_kind == KIND_PUSH) begin
            if (stat.full) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_FIN;
            end else begin
              cmd.push_init = 1'b1;
              state_nxt     = S_PUSH_RD;
            end
          end else begin
            if (stat.empty) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_FIN;
            end else begin
              cmd.pop_rd  = 1'b1;
              res_pop_nxt = 1'b1;
              state_nxt   = S_POP_LD;
            end
          end
        end
      end
      S_PUSH_RD: begin
        if (stat.at_root) begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.push_rd = 1'b1;
          state_nxt   = S_PUSH_CMP;
        end
      end
      S_PUSH_CMP: begin
        cmd.push_step = 1'b1;
        state_nxt     = stat.up_stop ? S_FIN : S_PUSH_RD;
      end
      S_POP_LD: begin
        cmd.pop_load = 1'b1;
        state_nxt    = S_DN_RD;
      end
      S_DN_RD: begin
        if (stat.leaf) begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.dn_rd = 1'b1;
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        cmd.dn_step = 1'b1;
        state_nxt   = stat.dn_stop ? S_FIN : S_DN_RD;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != S_IDLE)
    else $error("accepted transfer did not start an operation");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> state_r == S_FIN && (!out_valid_r || !out_stall))
    else $error("result loaded over a pending transfer");

  a_pop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP_LD |-> res_pop_r && res_status_r == ST_OK)
    else $error("pop flags inconsistent");

endmodule

// ===== design/serial_number_min_heap.sv =====
`timescale 1ns / 1ps
// A push on a full heap or a pop on an empty heap goes straight to the result state;
// the longest walk is a push that sifts 8 levels up to the root.
// Push sifts up one parent read and compare per level; pop sifts down one
// two-child read and compare per level, set by the single-write heap memory.
// One operation in flight; the next transfer is taken the cycle after the result
// is registered.
// Reset (rst_n low, synchronous) empties the heap; stored entries are not cleared.
module serial_number_min_heap (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  shp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output shp_pkg::out_t out_data
);
  import shp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  shp_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_data.kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  shp_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
